/* hw/rtl/bcrp_pkg.sv */
`default_nettype none
package bcrp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  localparam logic [WordW-1:0] ID_WORD      = 16'hBACD;
  localparam logic [WordW-1:0] PROJECT_WORD = 16'h0004;
  localparam logic [WordW-1:0] VERSION_WORD = 16'h0001;
  localparam logic [WordW-1:0] TOP_RESET    = 16'd32768;
  localparam logic [WordW-1:0] CMP_RESET    = 16'd16384;

  localparam logic [ByteW-1:0] CMD_RD_ID      = 8'h00;
  localparam logic [ByteW-1:0] CMD_RD_PROJECT = 8'h01;
  localparam logic [ByteW-1:0] CMD_RD_VERSION = 8'h02;
  localparam logic [ByteW-1:0] CMD_RD_TOP     = 8'h03;
  localparam logic [ByteW-1:0] CMD_RD_CMP     = 8'h04;
  localparam logic [ByteW-1:0] CMD_WR_TOP     = 8'h83;
  localparam logic [ByteW-1:0] CMD_WR_CMP     = 8'h84;

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  typedef enum logic {
    TGT_TOP = 1'b0,
    TGT_CMP = 1'b1
  } target_t;

  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] word;
  } word_push_t;

endpackage
`default_nettype wire

/* hw/rtl/bcrp_decode.sv */
`default_nettype none
module bcrp_decode (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [bcrp_pkg::ByteW-1:0] in_byte,
  input  wire logic                       in_message_end,
  output bcrp_pkg::word_push_t            push,
  input  wire logic                       push_ready
);
  import bcrp_pkg::*;

  logic             hold_valid_r, hold_valid_nxt;
  logic [ByteW-1:0] hold_byte_r;
  logic             hold_end_r;
  phase_t           phase_r, phase_nxt;
  target_t          target_r, target_nxt;
  logic [ByteW-1:0] low_hold_r, low_hold_nxt;
  logic [WordW-1:0] top_r, top_nxt;
  logic [WordW-1:0] cmp_r, cmp_nxt;
  logic             is_read;
  logic [WordW-1:0] read_word;
  logic             take;
  logic             load;

  always_comb begin
    is_read   = 1'b0;
    read_word = ID_WORD;
    case (hold_byte_r)
      CMD_RD_ID: begin
        is_read   = 1'b1;
        read_word = ID_WORD;
      end
      CMD_RD_PROJECT: begin
        is_read   = 1'b1;
        read_word = PROJECT_WORD;
      end
      CMD_RD_VERSION: begin
        is_read   = 1'b1;
        read_word = VERSION_WORD;
      end
      CMD_RD_TOP: begin
        is_read   = 1'b1;
        read_word = top_r;
      end
      CMD_RD_CMP: begin
        is_read   = 1'b1;
        read_word = cmp_r;
      end
      default: begin
        is_read = 1'b0;
      end
    endcase
    if ((phase_r == PH_LOW) || (phase_r == PH_HIGH)) begin
      is_read = 1'b0;
    end
  end

  assign take     = hold_valid_r && (!is_read || push_ready);
  assign in_stall = hold_valid_r && !take;
  assign load     = in_valid && !in_stall;

  assign push = '{valid: hold_valid_r && is_read && push_ready, word: read_word};

  always_comb begin
    phase_nxt      = phase_r;
    target_nxt     = target_r;
    low_hold_nxt   = low_hold_r;
    top_nxt        = top_r;
    cmp_nxt        = cmp_r;
    hold_valid_nxt = load || (hold_valid_r && !take);
    if (take) begin
      case (phase_r)
        PH_LOW: begin
          low_hold_nxt = hold_byte_r;
          phase_nxt    = hold_end_r ? PH_CMD : PH_HIGH;
        end
        PH_HIGH: begin
          if (target_r == TGT_CMP) begin
            cmp_nxt = {hold_byte_r, low_hold_r};
          end else begin
            top_nxt = {hold_byte_r, low_hold_r};
          end
          phase_nxt = PH_CMD;
        end
        default: begin
          phase_nxt = PH_CMD;
          if (((hold_byte_r == CMD_WR_TOP) || (hold_byte_r == CMD_WR_CMP)) && !hold_end_r) begin
            target_nxt = (hold_byte_r == CMD_WR_CMP) ? TGT_CMP : TGT_TOP;
            phase_nxt  = PH_LOW;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      phase_r      <= PH_CMD;
      target_r     <= TGT_TOP;
      low_hold_r   <= '0;
      top_r        <= TOP_RESET;
      cmp_r        <= CMP_RESET;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      phase_r      <= phase_nxt;
      target_r     <= target_nxt;
      low_hold_r   <= low_hold_nxt;
      top_r        <= top_nxt;
      cmp_r        <= cmp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_byte_r <= in_byte;
      hold_end_r  <= in_message_end;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/bcrp_tx.sv */
`default_nettype none
module bcrp_tx (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire bcrp_pkg::word_push_t       push,
  output logic                            push_ready,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [bcrp_pkg::ByteW-1:0]      out_byte,
  output logic                            out_pair_last
);
  import bcrp_pkg::*;

  logic [WordW-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             half_r, half_nxt;
  logic             beat;
  logic             pop;
  logic [WordW-1:0] head;

  assign head          = mem_r[rd_ptr_r];
  assign out_valid     = (count_r != 2'd0);
  assign out_byte      = half_r ? head[WordW-1:ByteW] : head[ByteW-1:0];
  assign out_pair_last = half_r;
  assign push_ready    = (count_r != 2'd2);
  assign beat          = out_valid && !out_stall;
  assign pop           = beat && half_r;

  always_comb begin
    half_nxt   = beat ? !half_r : half_r;
    wr_ptr_nxt = push.valid ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push.valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      half_r   <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      half_r   <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.word;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/byte_command_register_port.sv */
// Byte command register port.
// The input channel (in_valid, in_stall, in_byte, in_message_end) takes one
// message byte per beat; in_message_end marks the final byte of a message.
// Commands read the identification, project or version word, read the top or
// compare register, or write one of those two registers from the next two
// bytes, low byte first. Unknown commands are ignored and a write cut short by
// the end of its message is dropped.
// The result channel (out_valid, out_stall, out_byte, out_pair_last) gives two
// beats per read, low byte first; out_pair_last is high on the high byte.
// An accepted byte is held in an input register, where it is decoded; a read
// then writes its reply word into the reply queue, from which the low reply
// byte is shown, and the high byte can follow in the next cycle.
// One byte is accepted every cycle while in_stall is low; reads are limited by
// the result channel to two beats per word, with a two-word reply queue between
// decode and output. A stall on the result channel holds the current beat, and
// once the queue is full the input channel stalls on the next read command.
// Synchronous reset returns the top register to 32768, the compare register
// to 16384, empties the queue and leaves the block expecting a command byte.
`default_nettype none
module byte_command_register_port (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [bcrp_pkg::ByteW-1:0] in_byte,
  input  wire logic                       in_message_end,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [bcrp_pkg::ByteW-1:0]      out_byte,
  output logic                            out_pair_last
);
  import bcrp_pkg::*;

  word_push_t push;
  logic       push_ready;

  bcrp_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_message_end (in_message_end),
    .push           (push),
    .push_ready     (push_ready)
  );

  bcrp_tx u_tx (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .push_ready    (push_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_pair_last (out_pair_last)
  );

endmodule
`default_nettype wire

/* hw/rtl/bcrp_checker.sv */
`default_nettype none
module bcrp_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [bcrp_pkg::ByteW-1:0] out_byte,
  input wire logic                       out_pair_last
);

  a_reset_out_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown straight after reset");

  a_reset_in_open: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_pair_last))
    else $error("stalled result beat changed");

  a_high_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_pair_last |=> out_valid && out_pair_last)
    else $error("high reply byte did not follow the low byte");

  a_low_after_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_pair_last |=> !out_valid || !out_pair_last)
    else $error("reply word not opened by its low byte");

endmodule

bind byte_command_register_port bcrp_checker u_bcrp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .out_pair_last (out_pair_last)
);
`default_nettype wire

/* test/bcrp_reply_checker.sv */
`timescale 1ns / 100ps
module bcrp_reply_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [bcrp_pkg::ByteW-1:0] in_byte,
  input  logic                       in_message_end,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [bcrp_pkg::ByteW-1:0] out_byte,
  input  logic                       out_pair_last,
  output int                         mismatches,
  output int                         replies_owed
);
  import bcrp_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             pair_last;
  } reply_t;

  reply_t           reply_q[$];
  reply_t           owed;
  logic [WordW-1:0] top_reg;
  logic [WordW-1:0] cmp_reg;
  phase_t           phase;
  target_t          target;
  logic [ByteW-1:0] low_hold;

  task automatic queue_word(input logic [WordW-1:0] w);
    reply_q.push_back(reply_t'{data: w[ByteW-1:0], pair_last: 1'b0});
    reply_q.push_back(reply_t'{data: w[WordW-1:ByteW], pair_last: 1'b1});
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b, input logic last);
    case (phase)
      PH_LOW: begin
        low_hold = b;
        if (last) phase = PH_CMD;
        else phase = PH_HIGH;
      end
      PH_HIGH: begin
        if (target == TGT_CMP) cmp_reg = {b, low_hold};
        else top_reg = {b, low_hold};
        phase = PH_CMD;
      end
      default: begin
        phase = PH_CMD;
        case (b)
          CMD_RD_ID:      queue_word(ID_WORD);
          CMD_RD_PROJECT: queue_word(PROJECT_WORD);
          CMD_RD_VERSION: queue_word(VERSION_WORD);
          CMD_RD_TOP:     queue_word(top_reg);
          CMD_RD_CMP:     queue_word(cmp_reg);
          CMD_WR_TOP, CMD_WR_CMP: begin
            // A write command that closes its message is dropped.
            if (!last) begin
              if (b == CMD_WR_CMP) target = TGT_CMP;
              else target = TGT_TOP;
              phase = PH_LOW;
            end
          end
          default: ;
        endcase
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input int expected, input int actual);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, expected, actual);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      top_reg = TOP_RESET;
      cmp_reg = CMP_RESET;
      phase = PH_CMD;
      target = TGT_TOP;
      low_hold = '0;
      reply_q.delete();
      mismatches = 0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_byte, in_message_end);
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          note_mismatch("unexpected reply beat", 0, out_byte);
        end else begin
          owed = reply_q.pop_front();
          if (out_byte !== owed.data) note_mismatch("out_byte", owed.data, out_byte);
          if (out_pair_last !== owed.pair_last)
            note_mismatch("out_pair_last", owed.pair_last, out_pair_last);
        end
      end
    end
    replies_owed = reply_q.size();
  end

endmodule

/* test/tb_byte_command_register_port.sv */
`timescale 1ns / 100ps
module tb_byte_command_register_port;
  import bcrp_pkg::*;

  localparam int IdleLimit   = 5000;
  localparam int TargetItems = 950;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] in_byte = '0;
  logic             in_message_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ByteW-1:0] out_byte;
  logic             out_pair_last;
  int               mismatches;
  int               replies_owed;
  int               idle_cycles = 0;
  int               burst_left = 0;
  int               counted_items = 0;
  stall_mode_t      stall_mode = STALL_NONE;
  int               stall_phase = 0;
  logic [ByteW-1:0] msg_q[$];
  logic [ByteW-1:0] read_cmds[5] = '{CMD_RD_ID, CMD_RD_PROJECT, CMD_RD_VERSION,
                                     CMD_RD_TOP, CMD_RD_CMP};

  // Each entry holds the message-end flag above the byte.
  logic [ByteW:0] directed_beats[25] = '{
    {1'b1, CMD_RD_ID},
    {1'b0, CMD_RD_PROJECT}, {1'b0, CMD_RD_VERSION}, {1'b0, CMD_RD_TOP}, {1'b1, CMD_RD_CMP},
    {1'b0, CMD_WR_TOP}, {1'b0, 8'hFF}, {1'b1, 8'hFF}, {1'b1, CMD_RD_TOP},
    {1'b0, CMD_WR_CMP}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b1, CMD_RD_CMP},
    {1'b1, CMD_WR_TOP}, {1'b1, CMD_RD_ID},
    {1'b0, CMD_WR_CMP}, {1'b1, 8'h55}, {1'b1, CMD_RD_CMP},
    {1'b1, 8'hFF}, {1'b0, 8'h05}, {1'b1, 8'h80},
    {1'b0, CMD_WR_TOP}, {1'b0, 8'h5A}, {1'b1, 8'hA5}, {1'b1, CMD_RD_TOP}
  };

  byte_command_register_port dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_message_end (in_message_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_pair_last  (out_pair_last)
  );

  bcrp_reply_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_message_end (in_message_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_pair_last  (out_pair_last),
    .mismatches     (mismatches),
    .replies_owed   (replies_owed)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_phase <= $urandom_range(16, 96);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_phase % 5 < 2);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Bursts are mostly short; now and then a long one gives a stretch without gaps.
  task automatic send_beat(input logic [ByteW-1:0] b, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 120);
      else burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_message_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic [ByteW-1:0] data_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return ByteW'($urandom_range(0, 255));
  endfunction

  task automatic add_command();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      msg_q.push_back(read_cmds[$urandom_range(0, 4)]);
      counted_items++;
    end else if (pick < 9) begin
      msg_q.push_back($urandom_range(0, 1) ? CMD_WR_CMP : CMD_WR_TOP);
      msg_q.push_back(data_byte());
      msg_q.push_back(data_byte());
      counted_items += 3;
    end else begin
      msg_q.push_back(ByteW'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_message();
    int cut;
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 5)) msg_q.push_back(ByteW'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) add_command();
      // Some messages end early, often in the middle of a write.
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(0, msg_q.size() - 1);
        msg_q = msg_q[0:cut];
      end
    end
    foreach (msg_q[i]) send_beat(msg_q[i], i == msg_q.size() - 1);
    msg_q.delete();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_beats[i])
      send_beat(directed_beats[i][ByteW-1:0], directed_beats[i][ByteW]);
    counted_items = $size(directed_beats);
    while (counted_items < TargetItems) random_message();
    in_valid <= 1'b0;
    do @(negedge clk); while (replies_owed != 0);
    repeat (8) @(negedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* byte_command_register_port.f */
hw/rtl/bcrp_pkg.sv
hw/rtl/bcrp_decode.sv
hw/rtl/bcrp_tx.sv
hw/rtl/byte_command_register_port.sv
hw/rtl/bcrp_checker.sv
test/bcrp_reply_checker.sv
test/tb_byte_command_register_port.sv
